// File: design/adcalc_pkg.sv
`default_nettype none
package adcalc_pkg;

	// Item kinds on the command channel
	localparam logic [1:0] KIND_A    = 2'd0;
	localparam logic [1:0] KIND_B    = 2'd1;
	localparam logic [1:0] KIND_EXEC = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_BAD_OPERAND  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW     = 2'd2;
	localparam logic [1:0] ST_BAD_OPERATOR = 2'd3;

	// ASCII characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// Operand syntax phases
	localparam logic [2:0] PH_EMPTY  = 3'd0;
	localparam logic [2:0] PH_MINUS  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_DIGITS = 3'd3;
	localparam logic [2:0] PH_BAD    = 3'd4;

	// Magnitude limits of a 32-bit signed value
	localparam logic [35:0] POS_LIMIT = 36'h07FFF_FFFF;
	localparam logic [35:0] NEG_LIMIT = 36'h08000_0000;

	// floor(n / 10) == (n * RECIP_10) >> 35 for every 32-bit n
	localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam int          DIGITS_MAX  = 10;

	typedef struct packed {
		logic [31:0] mag;
		logic [2:0]  phase;
		logic        neg;
	} operand_t;

	// Controller to datapath
	typedef struct packed {
		logic take_char;
		logic exec;
		logic check;
		logic div_mul;
		logic div_rem;
		logic emit_fail;
		logic emit_sign;
		logic emit_digit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic exec_bad;
		logic overflow;
		logic negative;
		logic quot_zero;
		logic last_digit;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: design/adcalc_in_if.sv
`default_nettype none
interface adcalc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] symbol;
	logic [7:0] operator_code;

	modport source(output valid, output kind, output symbol, output operator_code,
		input ready);
	modport sink(input valid, input kind, input symbol, input operator_code,
		output ready);
endinterface
`default_nettype wire

// File: design/adcalc_out_if.sv
`default_nettype none
interface adcalc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_symbol;
	logic       end_of_result;
	logic [1:0] status;

	modport source(output valid, output out_symbol, output end_of_result, output status,
		input ready);
	modport sink(input valid, input out_symbol, input end_of_result, input status,
		output ready);
endinterface
`default_nettype wire

// File: design/adcalc_dp.sv
`default_nettype none
module adcalc_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [1:0]           kind,
	input  wire logic [7:0]           symbol,
	input  wire logic [7:0]           operator_code,
	input  wire adcalc_pkg::dp_cmd_t  ctl,
	output adcalc_pkg::dp_stat_t      stat,
	adcalc_out_if.source              result
);

	adcalc_pkg::operand_t opa_q, opb_q, opa_next, opb_next;
	logic [63:0] wide_q;
	logic        is_mul_q;
	logic        prod_neg_q;
	logic [1:0]  code_q;
	logic [31:0] conv_q;
	logic        res_neg_q;
	logic [3:0]  cnt_q;
	logic [3:0]  dig_q [adcalc_pkg::DIGITS_MAX];
	logic [7:0]  out_sym_q;
	logic        out_end_q;
	logic [1:0]  out_stat_q;
	logic        out_valid_q;

	logic        ok_a, ok_b, op_known, op_mul, op_sub;
	logic [1:0]  exec_code;
	logic [33:0] val_a, val_b, sum;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic        chk_neg, chk_ovf;
	logic [63:0] chk_mag;
	logic [33:0] sum_abs;
	logic [28:0] quot;
	logic [6:0]  quot_x10;
	logic [3:0]  rem;
	logic [3:0]  rd_idx;
	logic        out_free;

	// Advance one operand by one character
	function automatic adcalc_pkg::operand_t next_operand(adcalc_pkg::operand_t o,
		logic [7:0] c);
		adcalc_pkg::operand_t n;
		logic [35:0] m10;
		logic [35:0] lim;
		logic        is_dig;
		logic        is_nz;
		n      = o;
		is_dig = (c >= adcalc_pkg::CH_ZERO) && (c <= adcalc_pkg::CH_NINE);
		is_nz  = (c >= adcalc_pkg::CH_ONE) && (c <= adcalc_pkg::CH_NINE);
		m10    = {1'b0, o.mag, 3'b000} + {3'b000, o.mag, 1'b0} + {32'd0, c[3:0]};
		lim    = o.neg ? adcalc_pkg::NEG_LIMIT : adcalc_pkg::POS_LIMIT;
		case (o.phase)
			adcalc_pkg::PH_EMPTY: begin
				if (c == adcalc_pkg::CH_MINUS) begin
					n.phase = adcalc_pkg::PH_MINUS;
					n.neg   = 1'b1;
				end else if (c == adcalc_pkg::CH_ZERO) begin
					n.phase = adcalc_pkg::PH_ZERO;
				end else if (is_nz) begin
					n.phase = adcalc_pkg::PH_DIGITS;
					n.mag   = {28'd0, c[3:0]};
				end else begin
					n.phase = adcalc_pkg::PH_BAD;
				end
			end
			adcalc_pkg::PH_MINUS: begin
				if (is_nz) begin
					n.phase = adcalc_pkg::PH_DIGITS;
					n.mag   = {28'd0, c[3:0]};
				end else begin
					n.phase = adcalc_pkg::PH_BAD;
				end
			end
			adcalc_pkg::PH_DIGITS: begin
				if (!is_dig) begin
					n.phase = adcalc_pkg::PH_BAD;
				end else if (m10 > lim) begin
					n.phase = adcalc_pkg::PH_BAD;
					n.mag   = '0;
				end else begin
					n.mag = m10[31:0];
				end
			end
			default: n.phase = adcalc_pkg::PH_BAD;
		endcase
		return n;
	endfunction

	assign opa_next = next_operand(opa_q, symbol);
	assign opb_next = next_operand(opb_q, symbol);

	// Classify the execute item
	assign ok_a = (opa_q.phase == adcalc_pkg::PH_ZERO) || (opa_q.phase == adcalc_pkg::PH_DIGITS);
	assign ok_b = (opb_q.phase == adcalc_pkg::PH_ZERO) || (opb_q.phase == adcalc_pkg::PH_DIGITS);
	assign op_mul = (operator_code == adcalc_pkg::CH_STAR);
	assign op_sub = (operator_code == adcalc_pkg::CH_MINUS);
	assign op_known = op_mul || op_sub || (operator_code == adcalc_pkg::CH_PLUS);

	always_comb begin
		if (!ok_a || !ok_b) begin
			exec_code = adcalc_pkg::ST_BAD_OPERAND;
		end else if (!op_known) begin
			exec_code = adcalc_pkg::ST_BAD_OPERATOR;
		end else begin
			exec_code = adcalc_pkg::ST_OK;
		end
	end

	// Signed sum or difference of the operands
	assign val_a = opa_q.neg ? (34'd0 - {2'b00, opa_q.mag}) : {2'b00, opa_q.mag};
	assign val_b = opb_q.neg ? (34'd0 - {2'b00, opb_q.mag}) : {2'b00, opb_q.mag};
	assign sum   = op_sub ? (val_a - val_b) : (val_a + val_b);

	// Shared multiplier: operand product or reciprocal for the digit split
	assign mul_a = ctl.div_mul ? conv_q : opa_q.mag;
	assign mul_b = ctl.div_mul ? adcalc_pkg::RECIP_10 : opb_q.mag;
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

	// Sign, magnitude and range of the raw result
	assign sum_abs = wide_q[33] ? (34'd0 - wide_q[33:0]) : wide_q[33:0];
	always_comb begin
		if (is_mul_q) begin
			chk_neg = prod_neg_q && (wide_q != 64'd0);
			chk_mag = wide_q;
		end else begin
			chk_neg = wide_q[33];
			chk_mag = {30'd0, sum_abs};
		end
		if (chk_mag[63:32] != 32'd0) begin
			chk_ovf = 1'b1;
		end else if (chk_neg) begin
			chk_ovf = chk_mag[31:0] > adcalc_pkg::NEG_LIMIT[31:0];
		end else begin
			chk_ovf = chk_mag[31];
		end
	end

	// Quotient and remainder by ten
	assign quot     = wide_q[63:adcalc_pkg::RECIP_SHIFT];
	assign quot_x10 = {quot[3:0], 3'b000} + {2'b00, quot[3:0], 1'b0};
	assign rem      = conv_q[3:0] - quot_x10[3:0];
	assign rd_idx   = cnt_q - 4'd1;

	assign out_free = !out_valid_q || result.ready;

	assign stat.exec_bad   = (exec_code != adcalc_pkg::ST_OK);
	assign stat.overflow   = chk_ovf;
	assign stat.negative   = res_neg_q;
	assign stat.quot_zero  = (quot == 29'd0);
	assign stat.last_digit = (cnt_q == 4'd1);
	assign stat.out_free   = out_free;

	// Operand stores: take characters, clear on execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opa_q <= '{mag: '0, phase: adcalc_pkg::PH_EMPTY, neg: 1'b0};
			opb_q <= '{mag: '0, phase: adcalc_pkg::PH_EMPTY, neg: 1'b0};
		end else if (ctl.exec) begin
			opa_q <= '{mag: '0, phase: adcalc_pkg::PH_EMPTY, neg: 1'b0};
			opb_q <= '{mag: '0, phase: adcalc_pkg::PH_EMPTY, neg: 1'b0};
		end else if (ctl.take_char) begin
			if (kind == adcalc_pkg::KIND_A) begin
				opa_q <= opa_next;
			end
			if (kind == adcalc_pkg::KIND_B) begin
				opb_q <= opb_next;
			end
		end
	end

	// Result and digit split registers
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			wide_q     <= op_mul ? prod : {{30{sum[33]}}, sum};
			is_mul_q   <= op_mul;
			prod_neg_q <= opa_q.neg ^ opb_q.neg;
			code_q     <= exec_code;
		end
		if (ctl.check) begin
			res_neg_q <= chk_neg;
			conv_q    <= chk_mag[31:0];
			cnt_q     <= 4'd0;
			if (chk_ovf) begin
				code_q <= adcalc_pkg::ST_OVERFLOW;
			end
		end
		if (ctl.div_mul) begin
			wide_q <= prod;
		end
		if (ctl.div_rem) begin
			dig_q[cnt_q] <= rem;
			cnt_q        <= cnt_q + 4'd1;
			conv_q       <= {3'b000, quot};
		end
		if (ctl.emit_digit) begin
			cnt_q <= rd_idx;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctl.emit_fail) begin
			out_sym_q  <= 8'd0;
			out_end_q  <= 1'b1;
			out_stat_q <= code_q;
		end else if (ctl.emit_sign) begin
			out_sym_q  <= adcalc_pkg::CH_MINUS;
			out_end_q  <= 1'b0;
			out_stat_q <= adcalc_pkg::ST_OK;
		end else if (ctl.emit_digit) begin
			out_sym_q  <= adcalc_pkg::CH_ZERO + {4'd0, dig_q[rd_idx]};
			out_end_q  <= (cnt_q == 4'd1);
			out_stat_q <= adcalc_pkg::ST_OK;
		end
	end

	// Output register valid: set on a new beat, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_fail || ctl.emit_sign || ctl.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_symbol    = out_sym_q;
	assign result.end_of_result = out_end_q;
	assign result.status        = out_stat_q;

endmodule
`default_nettype wire

// File: design/adcalc_ctrl.sv
`default_nettype none
module adcalc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	adcalc_in_if.sink                 cmd,
	input  wire adcalc_pkg::dp_stat_t stat,
	output adcalc_pkg::dp_cmd_t       ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIVM  = 3'd2;
	localparam logic [2:0] S_DIVR  = 3'd3;
	localparam logic [2:0] S_SIGN  = 3'd4;
	localparam logic [2:0] S_DIGIT = 3'd5;
	localparam logic [2:0] S_FAIL  = 3'd6;

	logic [2:0] state_q, state_d;

	assign cmd.ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					if (cmd.kind inside {adcalc_pkg::KIND_A, adcalc_pkg::KIND_B}) begin
						ctl.take_char = 1'b1;
					end else if (cmd.kind == adcalc_pkg::KIND_EXEC) begin
						ctl.exec = 1'b1;
						state_d  = stat.exec_bad ? S_FAIL : S_CHECK;
					end
				end
			end
			S_CHECK: begin
				ctl.check = 1'b1;
				state_d   = stat.overflow ? S_FAIL : S_DIVM;
			end
			S_DIVM: begin
				ctl.div_mul = 1'b1;
				state_d     = S_DIVR;
			end
			S_DIVR: begin
				ctl.div_rem = 1'b1;
				if (stat.quot_zero) begin
					state_d = stat.negative ? S_SIGN : S_DIGIT;
				end else begin
					state_d = S_DIVM;
				end
			end
			S_SIGN: begin
				if (stat.out_free) begin
					ctl.emit_sign = 1'b1;
					state_d       = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (stat.out_free) begin
					ctl.emit_digit = 1'b1;
					if (stat.last_digit) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FAIL: begin
				if (stat.out_free) begin
					ctl.emit_fail = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: design/ascii_decimal_calculator.sv
// ASCII decimal calculator.
// cmd channel (valid/ready): one beat per item. kind 0 and 1 carry one ASCII
// character of the first or second operand in symbol; kind 2 executes with
// operator_code '+', '-' or '*'. kind 3 is taken and ignored.
// result channel (valid/ready): the result string, a '-' for negative values
// then the decimal digits, most significant first, end_of_result on the last
// beat, status 0. A failure is a single beat with out_symbol 0,
// end_of_result 1 and status 1 (bad operand), 2 (overflow) or 3 (bad operator).
// Characters are taken one per cycle while idle. An execute holds cmd.ready low
// while it runs: a range check, then a divide-by-ten loop per result digit
// (shared 32x32 multiplier, then remainder), then the output beats, which wait
// on receiver stalls. A failure beat is loaded from the FAIL state, entered from
// the execute beat or, for an overflow, from the range check.
// The output register holds a beat while result.ready is low; the block
// waits and loses nothing. Reset clears both operand stores and the output.
`default_nettype none
module ascii_decimal_calculator (
	input  wire logic    clk,
	input  wire logic    arst_n,
	adcalc_in_if.sink    cmd,
	adcalc_out_if.source result
);

	adcalc_pkg::dp_cmd_t  ctl;
	adcalc_pkg::dp_stat_t stat;

	adcalc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl)
	);

	adcalc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.kind          (cmd.kind),
		.symbol        (cmd.symbol),
		.operator_code (cmd.operator_code),
		.ctl           (ctl),
		.stat          (stat),
		.result        (result)
	);

	// A failure beat is always a lone, final, empty beat
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status != adcalc_pkg::ST_OK)
		|-> result.end_of_result && (result.out_symbol == 8'd0))
		else $error("failure beat malformed");

	// No new item is taken while a result is being produced
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit_fail || ctl.emit_sign || ctl.emit_digit || ctl.div_mul || ctl.div_rem)
		|-> !cmd.ready)
		else $error("item taken during execute");

	// An execute beat closes the command channel in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && (cmd.kind == adcalc_pkg::KIND_EXEC) |=> !cmd.ready)
		else $error("ready high after execute");

	// At most one output beat is loaded per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.emit_fail, ctl.emit_sign, ctl.emit_digit}))
		else $error("conflicting output loads");

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
module tb;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int ITEM_TARGET  = 450;
	localparam int IDLE_TARGET  = 250;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;

	// kind 3 is taken by the block and dropped
	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_X         = 8'h78;

	typedef logic [7:0] char_q_t[$];

	typedef struct {
		logic [35:0] mag;
		logic [2:0]  phase;
		logic        neg;
	} calc_operand_t;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
		logic [1:0] status;
	} result_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	adcalc_in_if  cmd();
	adcalc_out_if result();

	ascii_decimal_calculator u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.result(result)
	);

	calc_operand_t first_opnd;
	calc_operand_t second_opnd;
	result_beat_t  pending_beats[$];
	int            beat_errors = 0;
	int            items_sent  = 0;
	int            cycle_count = 0;
	int            hold_left   = 0;
	bit            tx_idle     = 1'b1;
	bit            rx_idle     = 1'b1;

	always #5 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ascii_decimal_calculator: mismatch");
			$finish;
		end
	end

	function automatic calc_operand_t empty_operand();
		calc_operand_t o;
		o.mag   = '0;
		o.phase = adcalc_pkg::PH_EMPTY;
		o.neg   = 1'b0;
		return o;
	endfunction

	// advance one operand's syntax phase and running magnitude by one character
	function automatic calc_operand_t absorb_char(calc_operand_t o, logic [7:0] c);
		logic        is_digit;
		logic        is_lead;
		logic [35:0] limit;
		is_digit = (c >= adcalc_pkg::CH_ZERO) && (c <= adcalc_pkg::CH_NINE);
		is_lead  = (c >= adcalc_pkg::CH_ONE) && (c <= adcalc_pkg::CH_NINE);
		limit    = o.neg ? adcalc_pkg::NEG_LIMIT : adcalc_pkg::POS_LIMIT;
		case (o.phase)
			adcalc_pkg::PH_EMPTY: begin
				if (c == adcalc_pkg::CH_MINUS) begin
					o.phase = adcalc_pkg::PH_MINUS;
					o.neg   = 1'b1;
				end else if (c == adcalc_pkg::CH_ZERO) begin
					o.phase = adcalc_pkg::PH_ZERO;
				end else if (is_lead) begin
					o.phase = adcalc_pkg::PH_DIGITS;
					o.mag   = 36'(c - adcalc_pkg::CH_ZERO);
				end else begin
					o.phase = adcalc_pkg::PH_BAD;
				end
			end
			adcalc_pkg::PH_MINUS: begin
				if (is_lead) begin
					o.phase = adcalc_pkg::PH_DIGITS;
					o.mag   = 36'(c - adcalc_pkg::CH_ZERO);
				end else begin
					o.phase = adcalc_pkg::PH_BAD;
				end
			end
			adcalc_pkg::PH_DIGITS: begin
				if (is_digit) begin
					o.mag = o.mag * 36'd10 + 36'(c - adcalc_pkg::CH_ZERO);
					if (o.mag > limit) begin
						o.phase = adcalc_pkg::PH_BAD;
						o.mag   = '0;
					end
				end else begin
					o.phase = adcalc_pkg::PH_BAD;
				end
			end
			default: o.phase = adcalc_pkg::PH_BAD;
		endcase
		return o;
	endfunction

	// evaluate the stored operands and queue the result beats, then clear both
	function automatic void evaluate_expression(logic [7:0] opc);
		logic       both_ok;
		logic [1:0] fail;
		longint     a;
		longint     b;
		longint     r;
		string      digits;
		both_ok = (first_opnd.phase == adcalc_pkg::PH_ZERO ||
			first_opnd.phase == adcalc_pkg::PH_DIGITS) &&
			(second_opnd.phase == adcalc_pkg::PH_ZERO ||
			second_opnd.phase == adcalc_pkg::PH_DIGITS);
		a = first_opnd.neg ? -longint'(first_opnd.mag) : longint'(first_opnd.mag);
		b = second_opnd.neg ? -longint'(second_opnd.mag) : longint'(second_opnd.mag);
		first_opnd  = empty_operand();
		second_opnd = empty_operand();
		r    = 0;
		fail = adcalc_pkg::ST_OK;
		if (!both_ok) begin
			fail = adcalc_pkg::ST_BAD_OPERAND;
		end else begin
			case (opc)
				adcalc_pkg::CH_PLUS:  r = a + b;
				adcalc_pkg::CH_MINUS: r = a - b;
				adcalc_pkg::CH_STAR:  r = a * b;
				default:              fail = adcalc_pkg::ST_BAD_OPERATOR;
			endcase
		end
		if (fail == adcalc_pkg::ST_OK && (r > 64'sd2147483647 || r < -64'sd2147483648))
			fail = adcalc_pkg::ST_OVERFLOW;
		if (fail != adcalc_pkg::ST_OK) begin
			pending_beats.push_back('{sym: 8'h00, last: 1'b1, status: fail});
		end else begin
			digits = $sformatf("%0d", r);
			for (int i = 0; i < digits.len(); i++)
				pending_beats.push_back('{sym: digits[i], last: (i == digits.len() - 1),
					status: adcalc_pkg::ST_OK});
		end
	endfunction

	// offer one command beat, wait for it to be taken, then update the predictor
	task automatic send_item(logic [1:0] kind, logic [7:0] sym, logic [7:0] opc);
		int gap;
		@(negedge clk);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.kind          <= kind;
		cmd.symbol        <= sym;
		cmd.operator_code <= opc;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		case (kind)
			adcalc_pkg::KIND_A:    first_opnd = absorb_char(first_opnd, sym);
			adcalc_pkg::KIND_B:    second_opnd = absorb_char(second_opnd, sym);
			adcalc_pkg::KIND_EXEC: evaluate_expression(opc);
			default:               ;
		endcase
		if (kind != KIND_IGNORED)
			items_sent++;
	endtask

	task automatic send_text(logic [1:0] kind, string text);
		for (int i = 0; i < text.len(); i++)
			send_item(kind, text[i], 8'($urandom));
	endtask

	function automatic char_q_t number_chars(longint v);
		string   s;
		char_q_t q;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic longint signed_rand(int unsigned limit);
		longint v;
		v = longint'($urandom_range(0, limit));
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [7:0] random_digit();
		return adcalc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// values at and just past the 32-bit limits, and factors near the overflow edge
	function automatic longint boundary_value();
		case ($urandom_range(0, 9))
			0:       return 64'sd2147483647;
			1:       return -64'sd2147483648;
			2:       return 64'sd2147483648;
			3:       return -64'sd2147483649;
			4:       return 64'sd46340;
			5:       return 64'sd46341;
			6:       return -64'sd46341;
			7:       return 64'sd65536;
			8:       return 64'sd1073741824;
			default: return -64'sd1;
		endcase
	endfunction

	// mostly well-formed operands, the rest malformed in each way the parser knows
	function automatic char_q_t random_operand();
		char_q_t q;
		case ($urandom_range(0, 19))
			0:             q.push_back(adcalc_pkg::CH_ZERO);
			1, 2, 3, 4, 5: q = number_chars(signed_rand(999));
			6, 7, 8:       q = number_chars(longint'(int'($urandom)));
			9, 10:         q = number_chars(boundary_value());
			11: begin
				// magnitude far past the 32-bit range
				q = number_chars(signed_rand(9));
				q.push_back(adcalc_pkg::CH_ONE);
				repeat ($urandom_range(9, 12)) q.push_back(random_digit());
			end
			12: ;
			13: q.push_back(adcalc_pkg::CH_MINUS);
			14: begin
				q.push_back(adcalc_pkg::CH_MINUS);
				q.push_back(adcalc_pkg::CH_ZERO);
				repeat ($urandom_range(0, 3)) q.push_back(random_digit());
			end
			15: begin
				q.push_back(adcalc_pkg::CH_ZERO);
				repeat ($urandom_range(1, 4)) q.push_back(random_digit());
			end
			16: begin
				q = number_chars(signed_rand(99999));
				q.insert($urandom_range(0, q.size()), 8'($urandom));
			end
			default: q = number_chars(signed_rand(99999));
		endcase
		return q;
	endfunction

	// interleave the characters of two operands, then execute
	task automatic send_expression();
		char_q_t    first_chars;
		char_q_t    second_chars;
		logic [7:0] opc;
		first_chars  = random_operand();
		second_chars = random_operand();
		while (first_chars.size() + second_chars.size() != 0) begin
			if ($urandom_range(0, 29) == 0)
				send_item(KIND_IGNORED, 8'($urandom), 8'($urandom));
			if (second_chars.size() == 0 || (first_chars.size() != 0 && $urandom_range(0, 1)))
				send_item(adcalc_pkg::KIND_A, first_chars.pop_front(), 8'($urandom));
			else
				send_item(adcalc_pkg::KIND_B, second_chars.pop_front(), 8'($urandom));
		end
		case ($urandom_range(0, 9))
			0, 1, 2: opc = adcalc_pkg::CH_PLUS;
			3, 4, 5: opc = adcalc_pkg::CH_MINUS;
			6, 7, 8: opc = adcalc_pkg::CH_STAR;
			default: opc = 8'($urandom);
		endcase
		send_item(adcalc_pkg::KIND_EXEC, 8'($urandom), opc);
	endtask

	// the minimum value must print its true final digit
	task automatic test_min_value_print();
		send_text(adcalc_pkg::KIND_A, "-1");
		send_text(adcalc_pkg::KIND_B, "2147483647");
		send_item(adcalc_pkg::KIND_EXEC, 8'h00, adcalc_pkg::CH_MINUS);
	endtask

	// lone minus and a leading zero both reject the expression
	task automatic test_malformed_operands();
		send_text(adcalc_pkg::KIND_A, "-");
		send_text(adcalc_pkg::KIND_B, "07");
		send_item(adcalc_pkg::KIND_EXEC, 8'h00, adcalc_pkg::CH_PLUS);
	endtask

	// a bad operand outranks a bad operator; ignored kind leaves the stores alone
	task automatic test_failure_precedence();
		send_item(adcalc_pkg::KIND_A, CH_X, 8'hFF);
		send_item(adcalc_pkg::KIND_EXEC, 8'hFF, CH_SLASH);
		send_item(adcalc_pkg::KIND_A, adcalc_pkg::CH_ZERO, 8'h00);
		send_item(KIND_IGNORED, 8'hFF, 8'hFF);
		send_item(adcalc_pkg::KIND_B, adcalc_pkg::CH_ZERO, 8'h00);
		send_item(adcalc_pkg::KIND_EXEC, 8'h00, 8'hFF);
	endtask

	task automatic test_random_traffic(int target, bit with_idling);
		while (items_sent < target) begin
			tx_idle = with_idling && ($urandom_range(0, 3) != 0);
			rx_idle = with_idling && ($urandom_range(0, 3) != 0);
			send_expression();
		end
	endtask

	// hold the result side off while commands keep coming, so the input stalls
	task automatic test_output_backpressure();
		tx_idle   = 1'b0;
		rx_idle   = 1'b0;
		hold_left = HOLD_CYCLES;
		repeat (4) send_expression();
	endtask

	// result-side ready: long hold-offs, random stall bursts, otherwise ready
	initial begin
		int stall_left;
		stall_left   = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	function automatic void flag_beat(string what, result_beat_t want, result_beat_t got);
		beat_errors++;
		if (beat_errors <= REPORT_MAX)
			$display("%0t %s: expected sym=%h last=%b status=%0d, %s",
				$time, what, want.sym, want.last, want.status,
				$sformatf("got sym=%h last=%b status=%0d", got.sym, got.last, got.status));
	endfunction

	// compare each accepted result beat with the oldest expected one
	always @(posedge clk) begin
		result_beat_t got;
		result_beat_t want;
		if (arst_n && result.valid && result.ready) begin
			got = '{sym: result.out_symbol, last: result.end_of_result, status: result.status};
			if (pending_beats.size() == 0) begin
				flag_beat("beat with nothing expected", '0, got);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want)
					flag_beat("wrong beat", want, got);
			end
		end
	end

	initial begin
		cmd.valid         = 1'b0;
		cmd.kind          = adcalc_pkg::KIND_A;
		cmd.symbol        = '0;
		cmd.operator_code = '0;
		first_opnd        = empty_operand();
		second_opnd       = empty_operand();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_min_value_print();
		test_malformed_operands();
		test_failure_precedence();
		test_random_traffic(IDLE_TARGET, 1'b1);
		test_output_backpressure();
		test_random_traffic(ITEM_TARGET, 1'b0);

		// drop valid and drain every expected beat
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (beat_errors == 0 && pending_beats.size() == 0)
			$display("ascii_decimal_calculator: match");
		else
			$display("ascii_decimal_calculator: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
design/adcalc_pkg.sv
design/adcalc_in_if.sv
design/adcalc_out_if.sv
design/adcalc_dp.sv
design/adcalc_ctrl.sv
design/ascii_decimal_calculator.sv
verif/tb.sv
